/* hw/rtl/kbs_pkg.sv */
// shared constants and control types of the key block sorter
package kbs_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_DESC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_SIGNED = 1'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // latch the incoming key beat
    logic read_prev;   // read the entry just below the insert position
    logic shift;       // move the entry up one slot, step the position down
    logic place;       // write the key at the insert position, count it
    logic emit_start;  // read the first sorted entry
    logic emit_load;   // load the result register, read the next entry
  } kbs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic last;
    logic pos_zero;
    logic pos_one;
    logic precedes;
    logic final_entry;
    logic out_free;
  } kbs_status_t;

endpackage

/* hw/rtl/key_block_sorter_top.sv */
// key block sorter: insertion sort of key blocks, sorted read-out on the block end
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    key_value, block_end
//   out      source     out_valid/out_stall  sorted_key, final_key, overflowed
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// the next key beat is held off while the stored keys that the key precedes are
// shifted up, one per cycle through the single write port of the key store;
// a key into an empty store or a dropped key needs no shift
// read-out starts after the block is complete, then one result per
// cycle while out_stall is low; the result register lets the next block start
// reset is synchronous and leaves the store empty, no clearing pass is needed
module key_block_sorter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   key_value,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   sorted_key,
  output logic                          final_key,
  output logic                          overflowed
);

  kbs_pkg::kbs_cmd_t    cmd;
  kbs_pkg::kbs_status_t status;

  kbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kbs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key_value  (key_value),
    .block_end  (block_end),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sorted_key (sorted_key),
    .final_key  (final_key),
    .overflowed (overflowed),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

/* hw/rtl/kbs_datapath.sv */
// key store, insertion compare, counters, config and result register
module kbs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]                   key_value,
  input  logic                          block_end,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [31:0]                   sorted_key,
  output logic                          final_key,
  output logic                          overflowed,
  input  kbs_pkg::kbs_cmd_t             cmd,
  output kbs_pkg::kbs_status_t          status
);

  logic                          order_desc;
  logic                          keys_sgn;
  logic [kbs_pkg::KEY_W-1:0]     key;
  logic                          last;
  logic [kbs_pkg::CNT_W-1:0]     count;
  logic [kbs_pkg::CNT_W-1:0]     pos;
  logic [kbs_pkg::CNT_W-1:0]     k;
  logic                          ovf;
  logic [kbs_pkg::KEY_W-1:0]     mem [kbs_pkg::MAX_KEYS];
  logic [kbs_pkg::KEY_W-1:0]     rd_data;

  logic [kbs_pkg::CNT_W-1:0]     pos_m1;
  logic [kbs_pkg::CNT_W-1:0]     pos_m2;
  logic [kbs_pkg::CNT_W-1:0]     k_p1;
  logic                          mem_we;
  logic [kbs_pkg::ADDR_W-1:0]    mem_waddr;
  logic [kbs_pkg::KEY_W-1:0]     mem_wdata;
  logic                          mem_re;
  logic [kbs_pkg::ADDR_W-1:0]    mem_raddr;
  logic [kbs_pkg::KEY_W-1:0]     key_cmp;
  logic [kbs_pkg::KEY_W-1:0]     rd_cmp;
  logic                          is_final;
  logic                          full;

  assign pos_m1   = pos - kbs_pkg::CNT_W'(1);
  assign pos_m2   = pos - kbs_pkg::CNT_W'(2);
  assign k_p1     = k + kbs_pkg::CNT_W'(1);
  assign is_final = (k_p1 == count);
  assign full     = (count == kbs_pkg::CNT_W'(kbs_pkg::MAX_KEYS));

  // flipping the sign bit turns a signed compare into an unsigned one
  assign key_cmp = {key[kbs_pkg::KEY_W-1] ^ keys_sgn, key[kbs_pkg::KEY_W-2:0]};
  assign rd_cmp  = {rd_data[kbs_pkg::KEY_W-1] ^ keys_sgn, rd_data[kbs_pkg::KEY_W-2:0]};

  assign mem_we    = cmd.shift | cmd.place;
  assign mem_waddr = pos[kbs_pkg::ADDR_W-1:0];
  assign mem_wdata = cmd.shift ? rd_data : key;
  assign mem_re    = cmd.read_prev | cmd.shift | cmd.emit_start | cmd.emit_load;

  always_comb begin
    mem_raddr = k_p1[kbs_pkg::ADDR_W-1:0];
    if (cmd.read_prev) begin
      mem_raddr = pos_m1[kbs_pkg::ADDR_W-1:0];
    end else if (cmd.shift) begin
      // below slot zero the read is junk and never used
      mem_raddr = pos_m2[kbs_pkg::ADDR_W-1:0];
    end else if (cmd.emit_start) begin
      mem_raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_desc <= 1'b0;
      keys_sgn   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kbs_pkg::CFG_ORDER_DESC:  order_desc <= cfg_data[0];
        kbs_pkg::CFG_KEYS_SIGNED: keys_sgn   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key  <= key_value[kbs_pkg::KEY_W-1:0];
      last <= block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
      k     <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pos <= count;
        if (full) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.shift) begin
        pos <= pos_m1;
      end
      if (cmd.place) begin
        count <= count + kbs_pkg::CNT_W'(1);
      end
      if (cmd.emit_start) begin
        k <= '0;
      end
      if (cmd.emit_load) begin
        k <= k_p1;
        if (is_final) begin
          count <= '0;
          ovf   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      sorted_key <= rd_data;
      final_key  <= is_final;
      overflowed <= ovf;
    end
  end

  assign status.full        = full;
  assign status.last        = last;
  assign status.pos_zero    = (pos == '0);
  assign status.pos_one     = (pos == kbs_pkg::CNT_W'(1));
  assign status.precedes    = order_desc ? (key_cmp > rd_cmp) : (key_cmp < rd_cmp);
  assign status.final_entry = is_final;
  assign status.out_free    = !out_valid || !out_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= kbs_pkg::CNT_W'(kbs_pkg::MAX_KEYS))
    else $error("key count beyond capacity");

  a_shift_above_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> pos != '0)
    else $error("shift below the bottom slot");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> count != '0)
    else $error("result loaded from an empty store");

endmodule

/* hw/rtl/kbs_ctrl.sv */
// controller state machine for insertion and sorted read-out
module kbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kbs_pkg::kbs_status_t status,
  output kbs_pkg::kbs_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_RD    = 3'd1;
  localparam logic [2:0] S_INS_CMP   = 3'd2;
  localparam logic [2:0] S_INS_PLACE = 3'd3;
  localparam logic [2:0] S_EMIT_RD   = 3'd4;
  localparam logic [2:0] S_EMIT_LD   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after_ins;

  assign in_stall  = (state != S_IDLE);
  assign after_ins = status.last ? S_EMIT_RD : S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (status.full) begin
          // key dropped, overflow already noted
          state_next = after_ins;
        end else if (status.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = after_ins;
        end else begin
          cmd.read_prev = 1'b1;
          state_next    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.precedes) begin
          cmd.shift = 1'b1;
          if (status.pos_one) begin
            state_next = S_INS_PLACE;
          end
        end else begin
          cmd.place  = 1'b1;
          state_next = after_ins;
        end
      end
      S_INS_PLACE: begin
        cmd.place  = 1'b1;
        state_next = after_ins;
      end
      S_EMIT_RD: begin
        cmd.emit_start = 1'b1;
        state_next     = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.final_entry) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_CMP |-> !status.full)
    else $error("insertion into a full store");

endmodule
